// ===== hw/rtl/spa_pkg.sv =====
// Shared types, constants and helper functions for the storage partition allocator.
// Used by spa_div100, spa_ctrl, spa_datapath and storage_partition_allocator_core.
// No dependencies.
`default_nettype none

package spa_pkg;

  // Table geometry.
  localparam int unsigned PARTITIONS = 16;
  localparam int unsigned GROUPS     = 8;
  localparam int unsigned PART_W     = $clog2(PARTITIONS);
  localparam int unsigned GROUP_W    = $clog2(GROUPS);

  // Field widths.
  localparam int unsigned BYTES_W    = 47;
  localparam int unsigned AMT_W      = BYTES_W + 1;
  localparam int unsigned OVH_W      = 10;
  localparam int unsigned FUZZ_W     = 7;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = BYTES_W;

  localparam logic [BYTES_W-1:0] MAX_BYTES = '1;

  // Percent arithmetic.
  localparam int unsigned PCT_SCALE     = 100;
  localparam int unsigned FIRST_FIT_PCT = 100;
  localparam int unsigned SUM_W         = BYTES_W + 5;  // request plus padding
  localparam int unsigned CMP_W         = BYTES_W + 9;  // fuzz cross-multiply

  // Divide-by-100 unit: one 8-bit digit per step, quotient estimated by a
  // reciprocal multiply that is exact for every partial remainder below 25600.
  localparam int unsigned DIV_W           = 64;
  localparam int unsigned DIV_DIGIT_W     = 8;
  localparam int unsigned DIV_STEPS       = DIV_W / DIV_DIGIT_W;
  localparam int unsigned DIV_REM_W       = 7;
  localparam int unsigned DIV_X_W         = DIV_REM_W + DIV_DIGIT_W;
  localparam int unsigned DIV_RECIP_W     = 13;
  localparam int unsigned DIV_EST_W       = DIV_X_W + DIV_RECIP_W;
  localparam int unsigned DIV_RECIP       = 5243;
  localparam int unsigned DIV_RECIP_SHIFT = 19;

  // Partition flag bits.
  localparam int unsigned FLAG_REFRESH  = 0;
  localparam int unsigned FLAG_ADJUSTED = 1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_ADJUST  = 2'd1,
    OP_REFRESH = 2'd2,
    OP_LOAD    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_SPACE   = 2'd1,
    STAT_NOT_LOADED = 2'd2,
    STAT_DEFERRED   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_ALLOC = 2'd0,
    CFG_OVERHEAD  = 2'd1,
    CFG_FUZZ      = 2'd2
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic div_load;
    logic div_step;
    logic size;
    logic scan_fetch;
    logic scan_eval;
    logic commit;
    logic exec;
    logic finish;
  } cmd_t;

  // Next partition around the ring.
  function automatic logic [PART_W-1:0] next_part(input logic [PART_W-1:0] idx);
    logic [PART_W-1:0] nxt;
    if (idx == PART_W'(PARTITIONS - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + 1'b1;
    end
    return nxt;
  endfunction

  // Clamp a signed sum to the unsigned 47-bit byte range.
  function automatic logic [BYTES_W-1:0] clamp_bytes(input logic signed [BYTES_W+1:0] v);
    logic [BYTES_W-1:0] res;
    if (v[BYTES_W+1]) begin
      res = '0;
    end else if (v[BYTES_W]) begin
      res = MAX_BYTES;
    end else begin
      res = v[BYTES_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spa_div100.sv =====
// Iterative divide-by-100 unit, one 8-bit quotient digit per step.
// Depends on spa_pkg for widths and the reciprocal constant.
`default_nettype none

module spa_div100 (
  input  wire logic                     clk_i,
  input  wire logic                     load_i,
  input  wire logic                     step_i,
  input  wire logic [spa_pkg::DIV_W-1:0] dividend_i,
  output logic      [spa_pkg::DIV_W-1:0] quotient_o
);

  logic [spa_pkg::DIV_W-1:0]       dvd_q;
  logic [spa_pkg::DIV_W-1:0]       quo_q;
  logic [spa_pkg::DIV_REM_W-1:0]   rem_q;
  logic [spa_pkg::DIV_X_W-1:0]     part_x;
  logic [spa_pkg::DIV_EST_W-1:0]   est;
  logic [spa_pkg::DIV_DIGIT_W-1:0] digit;
  logic [spa_pkg::DIV_X_W-1:0]     back;
  logic [spa_pkg::DIV_X_W-1:0]     rem_full;

  // Partial remainder with the next dividend digit appended, and its quotient digit.
  always_comb begin
    part_x   = {rem_q, dvd_q[spa_pkg::DIV_W-1 -: spa_pkg::DIV_DIGIT_W]};
    est      = spa_pkg::DIV_EST_W'(part_x) *
               spa_pkg::DIV_EST_W'(spa_pkg::DIV_RECIP);
    digit    = est[spa_pkg::DIV_RECIP_SHIFT +: spa_pkg::DIV_DIGIT_W];
    back     = spa_pkg::DIV_X_W'(digit) * spa_pkg::DIV_X_W'(spa_pkg::PCT_SCALE);
    rem_full = part_x - back;
  end

  // Dividend shifts out at the top while quotient digits shift in at the bottom.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (step_i) begin
      dvd_q <= {dvd_q[spa_pkg::DIV_W-spa_pkg::DIV_DIGIT_W-1:0],
                {spa_pkg::DIV_DIGIT_W{1'b0}}};
      rem_q <= rem_full[spa_pkg::DIV_REM_W-1:0];
      quo_q <= {quo_q[spa_pkg::DIV_W-spa_pkg::DIV_DIGIT_W-1:0], digit};
    end
  end

  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/spa_ctrl.sv =====
// Controller state machine of the storage partition allocator.
// Depends on spa_pkg for the command struct and operation codes.
`default_nettype none

module spa_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [spa_pkg::OP_W-1:0] req_type_i,
  output logic                         busy_o,
  output logic                         done_o,
  output spa_pkg::cmd_t                cmd_o
);

  localparam int unsigned MAX_COUNT =
      (spa_pkg::PARTITIONS > spa_pkg::DIV_STEPS) ? spa_pkg::PARTITIONS : spa_pkg::DIV_STEPS;
  localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(spa_pkg::DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(spa_pkg::PARTITIONS);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_SIZE   = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_COMMIT = 8'b0010_0000,
    S_EXEC   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q;
  logic             accept;

  assign accept = start_i && (state_q == S_IDLE);

  // Next state, step counter and datapath commands.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d = (req_type_i == spa_pkg::OP_ALLOC) ? S_MUL : S_EXEC;
        end
      end
      S_MUL: begin
        cmd_o.div_load = 1'b1;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd_o.size = 1'b1;
        cnt_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // The first cycle only prefetches the entry after the last pick.
        cmd_o.scan_fetch = 1'b1;
        cmd_o.scan_eval  = (cnt_q != '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SCAN_LAST) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_FINISH;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers; the result strobe lines up with the datapath output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= (state_q == S_FINISH);
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  // An accepted transaction makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("block not busy after accepting a transaction");

  // A result strobe only follows the finish state.
  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_FINISH))
    else $error("result strobe without a finished transaction");

  // The scan covers the whole ring before the commit.
  a_scan_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && (cnt_q != SCAN_LAST) |=> (state_q == S_SCAN))
    else $error("partition scan ended early");

endmodule

`default_nettype wire

// ===== hw/rtl/spa_datapath.sv =====
// Datapath of the storage partition allocator: configuration, partition table,
// group usage, request padding, ring scan and result registers.
// Depends on spa_pkg and spa_div100.
`default_nettype none

module spa_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire spa_pkg::cmd_t                      cmd_i,
  input  wire logic        [spa_pkg::OP_W-1:0]       req_type_i,
  input  wire logic        [spa_pkg::GROUP_W-1:0]    group_id_i,
  input  wire logic        [spa_pkg::PART_W-1:0]     part_index_i,
  input  wire logic signed [spa_pkg::AMT_W-1:0]      amount_i,
  input  wire logic                               cfg_we_i,
  input  wire logic        [spa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [spa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic             [spa_pkg::STATUS_W-1:0]   status_o,
  output logic             [spa_pkg::PART_W-1:0]     chosen_part_o,
  output logic             [spa_pkg::BYTES_W-1:0]    granted_size_o,
  output logic             [spa_pkg::BYTES_W-1:0]    group_usage_o
);

  localparam int unsigned PARTITIONS = spa_pkg::PARTITIONS;
  localparam int unsigned GROUPS     = spa_pkg::GROUPS;
  localparam int unsigned PART_W     = spa_pkg::PART_W;
  localparam int unsigned GROUP_W    = spa_pkg::GROUP_W;
  localparam int unsigned BYTES_W    = spa_pkg::BYTES_W;
  localparam int unsigned AMT_W      = spa_pkg::AMT_W;
  localparam int unsigned OVH_W      = spa_pkg::OVH_W;
  localparam int unsigned FUZZ_W     = spa_pkg::FUZZ_W;
  localparam int unsigned SUM_W      = spa_pkg::SUM_W;
  localparam int unsigned CMP_W      = spa_pkg::CMP_W;
  localparam int unsigned DIV_W      = spa_pkg::DIV_W;

  // Configuration registers.
  logic [BYTES_W-1:0] min_alloc_q;
  logic [OVH_W-1:0]   ovh_q;
  logic [FUZZ_W-1:0]  fuzz_q;

  // Captured request.
  spa_pkg::op_e              op_q;
  logic [GROUP_W-1:0]        grp_q;
  logic [PART_W-1:0]         idx_q;
  logic signed [AMT_W-1:0]   amt_q;

  // Partition table and group state.
  logic               valid_q     [PARTITIONS];
  logic [BYTES_W-1:0] free_q      [PARTITIONS];
  logic [GROUP_W-1:0] pgrp_q      [PARTITIONS];
  logic [1:0]         flags_q     [PARTITIONS];
  logic [PART_W-1:0]  last_pick_q [GROUPS];
  logic [BYTES_W-1:0] usage_q     [GROUPS];

  // Allocation working registers.
  logic [BYTES_W-1:0] size_q;
  logic [PART_W-1:0]  rd_idx_q;
  logic [PART_W-1:0]  ent_idx_q;
  logic               ent_ok_q;
  logic [BYTES_W-1:0] ent_free_q;
  logic               found_q;
  logic [PART_W-1:0]  sel_q;
  logic [BYTES_W-1:0] maxfree_q;

  // Result registers.
  spa_pkg::status_e   res_status_q, res_status_d;
  logic [PART_W-1:0]  res_chosen_q, res_chosen_d;
  logic [BYTES_W-1:0] res_granted_q, res_granted_d;
  logic [GROUP_W-1:0] ug_q, ug_d;
  logic               res_we;

  // Table read port.
  logic [PART_W-1:0]  raddr;
  logic               rd_valid;
  logic [BYTES_W-1:0] rd_free;
  logic [GROUP_W-1:0] rd_grp;
  logic [1:0]         rd_flags;
  logic [GROUP_W-1:0] usage_raddr;
  logic [BYTES_W-1:0] rd_usage;

  // Table write controls.
  logic               free_we;
  logic [BYTES_W-1:0] free_wd;
  logic               flags_we;
  logic [1:0]         flags_wd;
  logic               load_we;
  logic               usage_we;
  logic [BYTES_W-1:0] usage_wd;
  logic               lp_we;

  // Arithmetic.
  logic [BYTES_W+OVH_W-1:0]   mul_prod;
  logic [DIV_W-1:0]           quotient;
  logic [SUM_W-1:0]           pad_sum;
  logic                       amt_pos;
  logic [BYTES_W-1:0]         size_d;
  logic signed [BYTES_W+1:0]  usage_sum;
  logic signed [BYTES_W+1:0]  free_diff;
  logic                       fit;
  logic [BYTES_W-1:0]         diff;
  logic [BYTES_W:0]           pair_sum;
  logic [CMP_W-1:0]           lhs;
  logic [CMP_W-1:0]           rhs;
  logic                       take;

  // Configuration writes; an index past the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_alloc_q <= '0;
      ovh_q       <= '0;
      fuzz_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spa_pkg::CFG_MIN_ALLOC: min_alloc_q <= cfg_wdata_i;
        spa_pkg::CFG_OVERHEAD:  ovh_q       <= cfg_wdata_i[OVH_W-1:0];
        spa_pkg::CFG_FUZZ:      fuzz_q      <= cfg_wdata_i[FUZZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= spa_pkg::op_e'(req_type_i);
      grp_q <= group_id_i;
      idx_q <= part_index_i;
      amt_q <= amount_i;
    end
  end

  // One shared read address for the partition table.
  always_comb begin
    if (cmd_i.scan_fetch) begin
      raddr = rd_idx_q;
    end else if (cmd_i.commit) begin
      raddr = sel_q;
    end else begin
      raddr = idx_q;
    end
    rd_valid    = valid_q[raddr];
    rd_free     = free_q[raddr];
    rd_grp      = pgrp_q[raddr];
    rd_flags    = flags_q[raddr];
    usage_raddr = cmd_i.finish ? ug_q : rd_grp;
    rd_usage    = usage_q[usage_raddr];
  end

  // Overhead product, then an iterative divide by 100.
  assign mul_prod = {{OVH_W{1'b0}}, amt_q[BYTES_W-1:0]} * {{BYTES_W{1'b0}}, ovh_q};

  spa_div100 u_div (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (DIV_W'(mul_prod)),
    .quotient_o (quotient)
  );

  // Padded size: only a positive request is padded, everything else gets the minimum.
  always_comb begin
    amt_pos = !amt_q[AMT_W-1] && (amt_q[BYTES_W-1:0] != '0);
    pad_sum = SUM_W'(amt_q[BYTES_W-1:0]) + quotient[SUM_W-1:0];
    if (!amt_pos || (pad_sum < SUM_W'(min_alloc_q))) begin
      size_d = min_alloc_q;
    end else if (pad_sum[SUM_W-1:BYTES_W] != '0) begin
      size_d = spa_pkg::MAX_BYTES;
    end else begin
      size_d = pad_sum[BYTES_W-1:0];
    end
  end

  // Scan decision for the prefetched entry.
  always_comb begin
    diff     = (maxfree_q > ent_free_q) ? (maxfree_q - ent_free_q) : (ent_free_q - maxfree_q);
    pair_sum = {1'b0, maxfree_q} + {1'b0, ent_free_q};
    lhs      = CMP_W'(diff) * CMP_W'(spa_pkg::PCT_SCALE);
    rhs      = CMP_W'(fuzz_q) * CMP_W'(pair_sum);
    take     = 1'b0;
    if (ent_ok_q) begin
      if (fuzz_q >= FUZZ_W'(spa_pkg::FIRST_FIT_PCT)) begin
        take = !found_q;
      end else if ((fuzz_q == '0) || !found_q) begin
        take = (ent_free_q > maxfree_q);
      end else begin
        take = (lhs > rhs);
      end
    end
  end

  assign fit = rd_valid && (rd_grp == grp_q) && (size_q <= rd_free);

  // Size register, ring pointer, entry prefetch and running best choice.
  always_ff @(posedge clk_i) begin
    if (cmd_i.size) begin
      size_q    <= size_d;
      rd_idx_q  <= spa_pkg::next_part(last_pick_q[grp_q]);
      found_q   <= 1'b0;
      sel_q     <= '0;
      maxfree_q <= '0;
    end else begin
      if (cmd_i.scan_fetch) begin
        rd_idx_q   <= spa_pkg::next_part(rd_idx_q);
        ent_idx_q  <= rd_idx_q;
        ent_ok_q   <= fit;
        ent_free_q <= rd_free;
      end
      if (cmd_i.scan_eval && take) begin
        found_q   <= 1'b1;
        sel_q     <= ent_idx_q;
        maxfree_q <= ent_free_q;
      end
    end
  end

  // Table updates and result values for allocate commits and the other operations.
  always_comb begin
    usage_sum = $signed({2'b00, rd_usage}) + $signed({amt_q[AMT_W-1], amt_q});
    free_diff = $signed({2'b00, rd_free}) - $signed({amt_q[AMT_W-1], amt_q});

    free_we  = 1'b0;
    free_wd  = rd_free;
    flags_we = 1'b0;
    flags_wd = rd_flags;
    load_we  = 1'b0;
    usage_we = 1'b0;
    usage_wd = rd_usage;
    lp_we    = 1'b0;

    res_we        = 1'b0;
    res_status_d  = spa_pkg::STAT_OK;
    res_chosen_d  = idx_q;
    res_granted_d = '0;
    ug_d          = grp_q;

    if (cmd_i.commit) begin
      res_we        = 1'b1;
      res_granted_d = size_q;
      if (found_q) begin
        free_we      = 1'b1;
        free_wd      = rd_free - size_q;
        flags_we     = 1'b1;
        flags_wd     = rd_flags;
        flags_wd[spa_pkg::FLAG_REFRESH] = 1'b1;
        lp_we        = 1'b1;
        res_chosen_d = sel_q;
      end else begin
        res_status_d = spa_pkg::STAT_NO_SPACE;
        res_chosen_d = '0;
      end
    end else if (cmd_i.exec) begin
      res_we = 1'b1;
      case (op_q)
        spa_pkg::OP_ADJUST: begin
          if (!rd_valid) begin
            res_status_d = spa_pkg::STAT_NOT_LOADED;
          end else begin
            ug_d     = rd_grp;
            usage_we = 1'b1;
            usage_wd = spa_pkg::clamp_bytes(usage_sum);
            free_we  = 1'b1;
            free_wd  = spa_pkg::clamp_bytes(free_diff);
            flags_we = 1'b1;
            flags_wd = rd_flags;
            flags_wd[spa_pkg::FLAG_ADJUSTED] = 1'b1;
          end
        end
        spa_pkg::OP_REFRESH: begin
          if (!rd_valid) begin
            res_status_d = spa_pkg::STAT_NOT_LOADED;
          end else begin
            ug_d = rd_grp;
            if (rd_flags[spa_pkg::FLAG_REFRESH] || !rd_flags[spa_pkg::FLAG_ADJUSTED]) begin
              // A negative measurement counts as a failed scan.
              if (amt_q[AMT_W-1]) begin
                res_status_d = spa_pkg::STAT_DEFERRED;
              end else begin
                free_we  = 1'b1;
                free_wd  = amt_q[BYTES_W-1:0];
                flags_we = 1'b1;
                flags_wd = '0;
              end
            end else begin
              // Adjusted since the last refresh: hold the measurement off once.
              flags_we = 1'b1;
              flags_wd = rd_flags;
              flags_wd[spa_pkg::FLAG_REFRESH] = 1'b1;
              res_status_d = spa_pkg::STAT_DEFERRED;
            end
          end
        end
        spa_pkg::OP_LOAD: begin
          load_we  = 1'b1;
          free_we  = 1'b1;
          free_wd  = amt_q[AMT_W-1] ? '0 : amt_q[BYTES_W-1:0];
          flags_we = 1'b1;
          flags_wd = '0;
        end
        default: ;
      endcase
    end
  end

  // Table state with defined reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PARTITIONS; i++) begin
        valid_q[i] <= 1'b0;
      end
      for (int g = 0; g < GROUPS; g++) begin
        last_pick_q[g] <= PART_W'(PARTITIONS - 1);
        usage_q[g]     <= '0;
      end
    end else begin
      if (load_we) begin
        valid_q[raddr] <= 1'b1;
      end
      if (lp_we) begin
        last_pick_q[grp_q] <= sel_q;
      end
      if (usage_we) begin
        usage_q[rd_grp] <= usage_wd;
      end
    end
  end

  // Entry payload; only read once the entry is marked valid.
  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_q[raddr] <= free_wd;
    end
    if (flags_we) begin
      flags_q[raddr] <= flags_wd;
    end
    if (load_we) begin
      pgrp_q[raddr] <= grp_q;
    end
  end

  // Result registers and the output stage.
  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_status_q  <= res_status_d;
      res_chosen_q  <= res_chosen_d;
      res_granted_q <= res_granted_d;
      ug_q          <= ug_d;
    end
    if (cmd_i.finish) begin
      status_o       <= res_status_q;
      chosen_part_o  <= res_chosen_q;
      granted_size_o <= res_granted_q;
      group_usage_o  <= rd_usage;
    end
  end

  // The debited partition always covers the granted size.
  a_commit_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && found_q |-> (size_q <= rd_free))
    else $error("allocation debits more than the partition holds");

  // The chosen partition is loaded and belongs to the requested group.
  a_commit_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && found_q |-> rd_valid && (rd_grp == grp_q))
    else $error("allocation picked a foreign or unloaded partition");

  // A load marks its entry valid.
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (op_q == spa_pkg::OP_LOAD) |=> valid_q[$past(idx_q)])
    else $error("loaded partition not marked valid");

endmodule

`default_nettype wire

// ===== hw/rtl/storage_partition_allocator_core.sv =====
// Top level of the storage partition allocator: controller plus datapath.
// Depends on spa_pkg, spa_ctrl, spa_datapath and spa_div100.
//
// Usage: a transaction is taken when start_i is high while busy_o is low.
// Each transaction returns exactly one result, shown for a single cycle with
// done_o high; the receiver cannot hold it, so it must capture the result in
// that cycle. Allocate steps through the overhead multiply, the divide-by-100
// unit that produces one 8-bit quotient digit per step, the forming of the
// padded size, the ring scan that reads one partition entry per cycle from
// the single table read port, then the table update and the output stage;
// the result strobe comes once the block is idle again, so a new transaction
// can be accepted along with it. Adjust, refresh and load go through the
// execute step and the output stage. Configuration writes through cfg_we_i
// take effect at once and belong in idle periods between transactions.
`default_nettype none

module storage_partition_allocator_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic        [spa_pkg::OP_W-1:0]       req_type_i,
  input  wire logic        [spa_pkg::GROUP_W-1:0]    group_id_i,
  input  wire logic        [spa_pkg::PART_W-1:0]     part_index_i,
  input  wire logic signed [spa_pkg::AMT_W-1:0]      amount_i,
  input  wire logic                                cfg_we_i,
  input  wire logic        [spa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [spa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                                     done_o,
  output logic             [spa_pkg::STATUS_W-1:0]   status_o,
  output logic             [spa_pkg::PART_W-1:0]     chosen_part_o,
  output logic             [spa_pkg::BYTES_W-1:0]    granted_size_o,
  output logic             [spa_pkg::BYTES_W-1:0]    group_usage_o
);

  spa_pkg::cmd_t cmd;

  spa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .cmd_o      (cmd)
  );

  spa_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (req_type_i),
    .group_id_i     (group_id_i),
    .part_index_i   (part_index_i),
    .amount_i       (amount_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .status_o       (status_o),
    .chosen_part_o  (chosen_part_o),
    .granted_size_o (granted_size_o),
    .group_usage_o  (group_usage_o)
  );

endmodule

`default_nettype wire

// ===== dv/spa_tb_pkg.sv =====
// Scoreboard for the storage partition allocator testbench: a transaction-level
// mirror of the partition table and a queue of the results it predicts.
// Depends on spa_pkg for widths, geometry and the operation and status codes.
package spa_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import spa_pkg::*;

  // One predicted result transaction.
  typedef struct {
    status_e            status;
    logic [PART_W-1:0]  part;
    logic [BYTES_W-1:0] granted;
    logic [BYTES_W-1:0] usage;
  } alloc_result_t;

  class alloc_scoreboard;
    // Mirror of the partition table and per-group bookkeeping.
    logic [BYTES_W-1:0] part_free   [PARTITIONS];
    bit                 part_loaded [PARTITIONS];
    logic [GROUP_W-1:0] part_grp    [PARTITIONS];
    logic [1:0]         part_flg    [PARTITIONS];
    logic [PART_W-1:0]  grp_last    [GROUPS];
    logic [BYTES_W-1:0] grp_usage   [GROUPS];

    // Mirror of the configuration registers.
    logic [BYTES_W-1:0] min_alloc;
    logic [OVH_W-1:0]   overhead;
    logic [FUZZ_W-1:0]  fuzz;

    alloc_result_t pending_results[$];
    int unsigned   errors;

    function new();
      for (int i = 0; i < PARTITIONS; i++) begin
        part_free[i]   = '0;
        part_loaded[i] = 1'b0;
        part_grp[i]    = '0;
        part_flg[i]    = '0;
      end
      for (int i = 0; i < GROUPS; i++) begin
        grp_last[i]  = PART_W'(PARTITIONS - 1);
        grp_usage[i] = '0;
      end
      min_alloc = '0;
      overhead  = '0;
      fuzz      = '0;
      errors    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_ALLOC: min_alloc = data[BYTES_W-1:0];
        CFG_OVERHEAD:  overhead  = data[OVH_W-1:0];
        CFG_FUZZ:      fuzz      = data[FUZZ_W-1:0];
        default: ;
      endcase
    endfunction

    function longint saturate_bytes(longint v);
      longint top;
      top = longint'(MAX_BYTES);
      if (v < 0) return 0;
      if (v > top) return top;
      return v;
    endfunction

    // Request padded by the overhead percent, raised to the minimum and
    // saturated at the largest byte count.
    function longint pad_request(longint a);
      longint s;
      if (a == 0) return longint'(min_alloc);
      s = a * longint'(overhead) / 100 + a;
      if (s < longint'(min_alloc)) s = longint'(min_alloc);
      if (s > longint'(MAX_BYTES)) s = longint'(MAX_BYTES);
      return s;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Update the mirror for an accepted request and queue its result.
    function void predict_request(op_e op, logic [GROUP_W-1:0] g, logic [PART_W-1:0] p,
                                  logic signed [AMT_W-1:0] amt);
      alloc_result_t      r;
      longint             a;
      longint             size;
      logic [63:0]        maxfree;
      logic [63:0]        cur;
      logic [63:0]        diff;
      bit                 found;
      int unsigned        sel;
      int unsigned        idx;
      logic [GROUP_W-1:0] ug;

      a         = longint'(amt);
      r.status  = STAT_OK;
      r.part    = p;
      r.granted = '0;
      ug        = g;

      case (op)
        OP_ALLOC: begin
          size    = pad_request(a);
          maxfree = '0;
          found   = 1'b0;
          sel     = 0;
          idx     = grp_last[g];
          // Walk the ring once, starting after the group's last pick.
          for (int k = 0; k < PARTITIONS; k++) begin
            idx = (idx + 1) % PARTITIONS;
            if (!part_loaded[idx] || part_grp[idx] != g) continue;
            if (size > longint'(part_free[idx])) continue;
            cur = 64'(part_free[idx]);
            if (fuzz >= FIRST_FIT_PCT) begin
              sel   = idx;
              found = 1'b1;
              break;
            end
            if (fuzz == 0 || !found) begin
              if (cur > maxfree) begin
                sel     = idx;
                maxfree = cur;
                found   = 1'b1;
              end
            end else begin
              diff = (maxfree > cur) ? maxfree - cur : cur - maxfree;
              if (diff * 64'd100 > 64'(fuzz) * (maxfree + cur)) begin
                sel     = idx;
                maxfree = cur;
              end
            end
          end
          r.granted = BYTES_W'(size);
          if (!found) begin
            r.status = STAT_NO_SPACE;
            r.part   = '0;
          end else begin
            grp_last[g]                  = PART_W'(sel);
            part_free[sel]               = part_free[sel] - BYTES_W'(size);
            part_flg[sel][FLAG_REFRESH]  = 1'b1;
            r.part                       = PART_W'(sel);
          end
        end
        OP_ADJUST: begin
          if (!part_loaded[p]) begin
            r.status = STAT_NOT_LOADED;
          end else begin
            ug            = part_grp[p];
            grp_usage[ug] = BYTES_W'(saturate_bytes(longint'(grp_usage[ug]) + a));
            part_free[p]  = BYTES_W'(saturate_bytes(longint'(part_free[p]) - a));
            part_flg[p][FLAG_ADJUSTED] = 1'b1;
          end
        end
        OP_REFRESH: begin
          if (!part_loaded[p]) begin
            r.status = STAT_NOT_LOADED;
          end else begin
            ug = part_grp[p];
            // A measurement taken after an adjust is deferred once.
            if (part_flg[p][FLAG_REFRESH] || !part_flg[p][FLAG_ADJUSTED]) begin
              if (a < 0) begin
                r.status = STAT_DEFERRED;
              end else begin
                part_free[p] = BYTES_W'(saturate_bytes(a));
                part_flg[p]  = '0;
              end
            end else begin
              part_flg[p][FLAG_REFRESH] = 1'b1;
              r.status                  = STAT_DEFERRED;
            end
          end
        end
        default: begin
          part_loaded[p] = 1'b1;
          part_grp[p]    = g;
          part_free[p]   = BYTES_W'(saturate_bytes(a));
          part_flg[p]    = '0;
        end
      endcase

      r.usage = grp_usage[ug];
      pending_results.push_back(r);
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void check_result(logic [STATUS_W-1:0] status, logic [PART_W-1:0] part,
                               logic [BYTES_W-1:0] granted, logic [BYTES_W-1:0] usage);
      alloc_result_t exp;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d part %0d", status, part);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        errors++;
      end
      if (part !== exp.part) begin
        $error("chosen_part: expected %0d, got %0d", exp.part, part);
        errors++;
      end
      if (granted !== exp.granted) begin
        $error("granted_size: expected %0d, got %0d", exp.granted, granted);
        errors++;
      end
      if (usage !== exp.usage) begin
        $error("group_usage: expected %0d, got %0d", exp.usage, usage);
        errors++;
      end
    endfunction

    function void report_leftovers();
      if (pending_results.size() != 0) begin
        $error("%0d results never arrived", pending_results.size());
        errors += pending_results.size();
      end
    endfunction
  endclass

endpackage

// ===== dv/tb_storage_partition_allocator_core.sv =====
// Testbench top for storage_partition_allocator_core: directed and random
// requests under several register settings, checked by the scoreboard.
// Depends on spa_pkg, spa_tb_pkg and the allocator RTL.
module tb_storage_partition_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import spa_pkg::*;
  import spa_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned PHASES = 7;
  localparam logic signed [AMT_W-1:0] AMT_MAX = {1'b0, MAX_BYTES};
  localparam logic signed [AMT_W-1:0] AMT_MIN = {1'b1, {BYTES_W{1'b0}}};

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic [OP_W-1:0]            req_type_i;
  logic [GROUP_W-1:0]         group_id_i;
  logic [PART_W-1:0]          part_index_i;
  logic signed [AMT_W-1:0]    amount_i;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_idx_i;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i;
  logic                       done_o;
  logic [STATUS_W-1:0]        status_o;
  logic [PART_W-1:0]          chosen_part_o;
  logic [BYTES_W-1:0]         granted_size_o;
  logic [BYTES_W-1:0]         group_usage_o;

  alloc_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int unsigned     item_count = 0;

  storage_partition_allocator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .group_id_i     (group_id_i),
    .part_index_i   (part_index_i),
    .amount_i       (amount_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .chosen_part_o  (chosen_part_o),
    .granted_size_o (granted_size_o),
    .group_usage_o  (group_usage_o)
  );

  always #10 clk_i = ~clk_i;

  // Results are checked before new requests are noted, since a result in
  // the same cycle always belongs to an earlier transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_result(status_o, chosen_part_o, granted_size_o, group_usage_o);
      end
      if (cfg_we_i) begin
        sb.set_reg(cfg_idx_e'(cfg_idx_i), cfg_wdata_i);
      end
      if (start_i && !busy_o) begin
        sb.predict_request(op_e'(req_type_i), group_id_i, part_index_i, amount_i);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic signed [AMT_W-1:0] wide_amount();
    logic signed [AMT_W-1:0] v;
    case ($urandom_range(3))
      0:       v = AMT_MIN;
      1:       v = AMT_MAX;
      default: v = AMT_W'({$urandom, $urandom});
    endcase
    return v;
  endfunction

  // Present one request and hold it until the block takes it. A gap, when
  // taken, lowers start for a random stretch that can cover the whole
  // allocate walk.
  task automatic issue_request(input op_e op, input logic [GROUP_W-1:0] g,
                               input logic [PART_W-1:0] p,
                               input logic signed [AMT_W-1:0] amt,
                               input int unsigned idle_pct);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 36)) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    req_type_i   <= op;
    group_id_i   <= g;
    part_index_i <= p;
    amount_i     <= amt;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    item_count++;
  endtask

  // Random request, biased toward a few groups so that scans find several
  // candidates, with small sizes so that partitions take many allocations.
  task automatic issue_random(input int unsigned idle_pct);
    op_e                     op;
    logic [GROUP_W-1:0]      g;
    int unsigned             roll;
    int                      v;
    logic signed [AMT_W-1:0] amt;
    roll = $urandom_range(99);
    op   = (roll < 40) ? OP_ALLOC : (roll < 55) ? OP_ADJUST :
           (roll < 70) ? OP_REFRESH : OP_LOAD;
    g    = ($urandom_range(3) == 0) ? GROUP_W'($urandom_range(7)) : GROUP_W'($urandom_range(2));
    roll = $urandom_range(99);
    case (op)
      OP_ALLOC: begin
        if (roll < 70) begin
          amt = AMT_W'($urandom_range(65535));
        end else if (roll < 80) begin
          v   = $urandom_range(1000);
          amt = AMT_W'(-v);
        end else if (roll < 90) begin
          amt = wide_amount();
        end else begin
          amt = AMT_W'($urandom_range(1 << 20));
        end
      end
      OP_ADJUST: begin
        if (roll < 85) begin
          v   = $urandom_range(8192);
          amt = AMT_W'(v - 4096);
        end else begin
          amt = wide_amount();
        end
      end
      OP_REFRESH: begin
        if (roll < 75) begin
          amt = AMT_W'($urandom_range(1 << 22));
        end else if (roll < 85) begin
          v   = $urandom_range(1, 100000);
          amt = AMT_W'(-v);
        end else begin
          amt = wide_amount();
        end
      end
      default: begin
        if (roll < 85) begin
          amt = AMT_W'($urandom_range(1 << 16, 1 << 22));
        end else begin
          amt = wide_amount();
        end
      end
    endcase
    issue_request(op, g, PART_W'($urandom_range(15)), amt, idle_pct);
  endtask

  // Drop start and wait until every outstanding result has come back.
  task automatic wait_quiet();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [BYTES_W-1:0] min_bytes,
                              input logic [OVH_W-1:0] ovh,
                              input logic [FUZZ_W-1:0] fz);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MIN_ALLOC;
    cfg_wdata_i <= min_bytes;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_OVERHEAD;
    cfg_wdata_i <= CFG_DATA_W'(ovh);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_FUZZ;
    cfg_wdata_i <= CFG_DATA_W'(fz);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned        idle_pct;
    logic [BYTES_W-1:0] min_bytes;
    logic [OVH_W-1:0]   ovh;
    logic [FUZZ_W-1:0]  fz;

    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_type_i   = OP_ALLOC;
    group_id_i   = '0;
    part_index_i = '0;
    amount_i     = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_MIN_ALLOC;
    cfg_wdata_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: unloaded partitions, empty table, load clamps, padded
    // size corners, adjust clamps and the refresh deferral sequence.
    program_regs(BYTES_W'(100), OVH_W'(10), FUZZ_W'(0));
    issue_request(OP_ADJUST,  3'd2, 4'd5,  48'sd7,    0);
    issue_request(OP_REFRESH, 3'd6, 4'd5,  48'sd9,    0);
    issue_request(OP_ALLOC,   3'd0, 4'd0,  48'sd10,   0);
    issue_request(OP_LOAD,    3'd0, 4'd0,  48'sd1000, 0);
    issue_request(OP_LOAD,    3'd0, 4'd1,  AMT_MAX,   0);
    issue_request(OP_LOAD,    3'd7, 4'd15, AMT_MIN,   0);
    issue_request(OP_LOAD,    3'd3, 4'd2,  -48'sd1,   0);
    issue_request(OP_ALLOC,   3'd0, 4'd9,  48'sd0,    0);
    issue_request(OP_ALLOC,   3'd0, 4'd9,  -48'sd5,   0);
    issue_request(OP_ALLOC,   3'd0, 4'd9,  AMT_MAX,   0);
    issue_request(OP_ALLOC,   3'd0, 4'd9,  48'sd500,  0);
    issue_request(OP_ADJUST,  3'd0, 4'd0,  AMT_MIN,   0);
    issue_request(OP_ADJUST,  3'd0, 4'd0,  AMT_MAX,   0);
    issue_request(OP_ADJUST,  3'd0, 4'd1,  AMT_MAX,   0);
    issue_request(OP_LOAD,    3'd1, 4'd3,  48'sd100,  0);
    issue_request(OP_ADJUST,  3'd5, 4'd3,  48'sd10,   0);
    issue_request(OP_REFRESH, 3'd5, 4'd3,  48'sd50,   0);
    issue_request(OP_REFRESH, 3'd5, 4'd3,  48'sd60,   0);
    issue_request(OP_REFRESH, 3'd5, 4'd3,  -48'sd1,   0);
    issue_request(OP_REFRESH, 3'd5, 4'd3,  AMT_MAX,   0);
    issue_request(OP_ALLOC,   3'd7, 4'd0,  48'sd1,    0);
    issue_request(OP_ALLOC,   3'd1, 4'd0,  48'sd50,   0);
    issue_request(OP_ADJUST,  3'd0, 4'd3,  AMT_MIN,   0);

    // Random part: one register setting per phase, the extremes included.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      case (ph)
        0: begin
          min_bytes = '0;
          ovh       = '0;
          fz        = '0;
        end
        1: begin
          min_bytes = MAX_BYTES;
          ovh       = OVH_W'(1000);
          fz        = FUZZ_W'(FIRST_FIT_PCT);
        end
        2: begin
          min_bytes = BYTES_W'($urandom_range(4095));
          ovh       = OVH_W'($urandom_range(1000));
          fz        = FUZZ_W'($urandom_range(1, 99));
        end
        3: begin
          min_bytes = BYTES_W'($urandom_range(255));
          ovh       = OVH_W'($urandom_range(50));
          fz        = '1;
        end
        4: begin
          min_bytes = BYTES_W'({$urandom, $urandom});
          ovh       = OVH_W'($urandom_range(1000));
          fz        = FUZZ_W'(50);
        end
        5: begin
          min_bytes = '0;
          ovh       = OVH_W'(1000);
          fz        = FUZZ_W'($urandom_range(1, 99));
        end
        default: begin
          min_bytes = BYTES_W'($urandom_range(4095));
          ovh       = OVH_W'($urandom_range(1000));
          fz        = FUZZ_W'($urandom_range(100));
        end
      endcase
      program_regs(min_bytes, ovh, fz);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Sender gaps: moderate first, heavy next, none at the end.
        idle_pct = (item_count < 256) ? 28 : (item_count < 490) ? 46 : 0;
        issue_random(idle_pct);
      end
    end

    // Drain and let any stray strobe show up before the verdict.
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.report_leftovers();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
